>>> hdl/akd_pkg.sv
// akd_pkg: shared types, constants and decode functions for the key sequence decoder
// no dependencies; used by akd_core and ansi_key_sequence_decoder
package akd_pkg;

  localparam int unsigned SEQ_MAX = 16;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned GAP_W   = 16;

  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(127);
  localparam logic [CNT_W-1:0] CNT_LIM  = CNT_W'(SEQ_MAX);
  localparam logic [GAP_W-1:0] GAP_SAT  = '1;
  localparam logic [GAP_W-1:0] GAP_RST  = GAP_W'(40);

  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_CSI    = 8'h5b;  // '['
  localparam logic [7:0] CH_SS3    = 8'h4f;  // 'O'
  localparam logic [7:0] CH_FIN_LO = 8'h40;
  localparam logic [7:0] CH_FIN_HI = 8'h7e;
  localparam logic [7:0] CH_UP     = 8'h41;
  localparam logic [7:0] CH_DOWN   = 8'h42;
  localparam logic [7:0] CH_RIGHT  = 8'h43;
  localparam logic [7:0] CH_LEFT   = 8'h44;
  localparam logic [7:0] CH_FIVE   = 8'h35;
  localparam logic [7:0] CH_SIX    = 8'h36;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_NAK    = 8'd21;
  localparam logic [7:0] CH_ETX    = 8'd3;
  localparam logic [7:0] CH_PRINT  = 8'd33;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    KEY_NONE    = 4'd0,
    KEY_UP      = 4'd1,
    KEY_DOWN    = 4'd2,
    KEY_RIGHT   = 4'd3,
    KEY_LEFT    = 4'd4,
    KEY_ENTER   = 4'd5,
    KEY_REFRESH = 4'd6,
    KEY_ERASE   = 4'd7,
    KEY_CLEAR   = 4'd8,
    KEY_QUIT    = 4'd9,
    KEY_BACK    = 4'd10,
    KEY_CHAR    = 4'd11
  } key_t;

  typedef struct packed {
    logic       valid;
    key_t       kind;
    logic [7:0] code;
  } result_t;

  function automatic key_t decode_body(input logic [CNT_W-1:0] cnt,
                                       input logic [7:0] first,
                                       input logic [7:0] second);
    key_t k;
    k = KEY_NONE;
    if (cnt == CNT_W'(1)) begin
      if (first == CH_UP) k = KEY_UP;
      else if (first == CH_DOWN) k = KEY_DOWN;
      else if (first == CH_RIGHT) k = KEY_RIGHT;
      else if (first == CH_LEFT) k = KEY_LEFT;
    end else if (cnt == CNT_W'(2) && second == CH_TILDE) begin
      if (first == CH_FIVE) k = KEY_LEFT;
      else if (first == CH_SIX) k = KEY_RIGHT;
    end
    return k;
  endfunction

  function automatic key_t plain_key(input logic [7:0] b);
    key_t k;
    if (b == CH_CR || b == CH_LF) k = KEY_ENTER;
    else if (b == CH_SPACE) k = KEY_REFRESH;
    else if (b == CH_BS || b == CH_DEL) k = KEY_ERASE;
    else if (b == CH_NAK) k = KEY_CLEAR;
    else if (b == CH_ETX) k = KEY_QUIT;
    else if (b >= CH_PRINT) k = KEY_CHAR;
    else k = KEY_NONE;
    return k;
  endfunction

endpackage

>>> hdl/akd_core.sv
// akd_core: escape sequence state machine, gap timer and key decode
// depends on akd_pkg
module akd_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic                       mode,
  input  logic [7:0]                 byte_value,
  input  logic [akd_pkg::GAP_W-1:0]  gap_ticks,
  output akd_pkg::result_t           res
);

  akd_pkg::phase_t             phase, phase_next;
  logic [akd_pkg::CNT_W-1:0]   body_count, body_count_next;
  logic [7:0]                  first_body_byte, first_body_byte_next;
  logic [7:0]                  second_body_byte, second_body_byte_next;
  logic [akd_pkg::GAP_W-1:0]   gap_counter, gap_counter_next;

  logic [akd_pkg::GAP_W-1:0]   gap_inc;
  logic [akd_pkg::GAP_W-1:0]   gap_limit;
  logic                        expired;
  logic [akd_pkg::CNT_W-1:0]   cnt_inc;
  logic                        is_final;

  assign gap_inc   = (gap_counter == akd_pkg::GAP_SAT) ? gap_counter
                                                       : gap_counter + 1'b1;
  assign gap_limit = (gap_ticks == '0) ? akd_pkg::GAP_W'(1) : gap_ticks;
  assign expired   = gap_inc >= gap_limit;
  assign cnt_inc   = (body_count == akd_pkg::CNT_SAT) ? body_count
                                                      : body_count + 1'b1;
  assign is_final  = (byte_value >= akd_pkg::CH_FIN_LO && byte_value <= akd_pkg::CH_FIN_HI)
                     || cnt_inc >= akd_pkg::CNT_LIM;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= akd_pkg::PH_IDLE;
      body_count       <= '0;
      first_body_byte  <= '0;
      second_body_byte <= '0;
      gap_counter      <= '0;
    end else if (step) begin
      phase            <= phase_next;
      body_count       <= body_count_next;
      first_body_byte  <= first_body_byte_next;
      second_body_byte <= second_body_byte_next;
      gap_counter      <= gap_counter_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    body_count_next       = body_count;
    first_body_byte_next  = first_body_byte;
    second_body_byte_next = second_body_byte;
    gap_counter_next      = gap_counter;
    res.valid             = 1'b0;
    res.kind              = akd_pkg::KEY_NONE;
    res.code              = '0;
    case (phase)
      akd_pkg::PH_ESC: begin
        if (mode) begin
          gap_counter_next = gap_inc;
          if (expired) begin
            phase_next = akd_pkg::PH_IDLE;
            res.valid  = 1'b1;
            res.kind   = akd_pkg::KEY_BACK;
          end
        end else begin
          gap_counter_next = '0;
          if (byte_value == akd_pkg::CH_CSI || byte_value == akd_pkg::CH_SS3) begin
            phase_next            = akd_pkg::PH_BODY;
            body_count_next       = '0;
            first_body_byte_next  = '0;
            second_body_byte_next = '0;
          end else begin
            phase_next = akd_pkg::PH_IDLE;
            res.valid  = 1'b1;
          end
        end
      end
      akd_pkg::PH_BODY: begin
        if (mode) begin
          gap_counter_next = gap_inc;
          if (expired) begin
            phase_next = akd_pkg::PH_IDLE;
            res.valid  = 1'b1;
            res.kind   = akd_pkg::decode_body(body_count, first_body_byte,
                                              second_body_byte);
          end
        end else begin
          gap_counter_next = '0;
          if (body_count == '0) first_body_byte_next = byte_value;
          else if (body_count == akd_pkg::CNT_W'(1)) second_body_byte_next = byte_value;
          body_count_next = cnt_inc;
          if (is_final) begin
            phase_next = akd_pkg::PH_IDLE;
            res.valid  = 1'b1;
            res.kind   = akd_pkg::decode_body(cnt_inc, first_body_byte_next,
                                              second_body_byte_next);
          end
        end
      end
      default: begin
        phase_next = akd_pkg::PH_IDLE;
        if (!mode) begin
          if (byte_value == akd_pkg::CH_ESC) begin
            phase_next       = akd_pkg::PH_ESC;
            gap_counter_next = '0;
            body_count_next  = '0;
          end else begin
            res.valid = 1'b1;
            res.kind  = akd_pkg::plain_key(byte_value);
            if (res.kind == akd_pkg::KEY_CHAR) res.code = byte_value;
          end
        end
      end
    endcase
  end

`ifndef SYNTHESIS
  a_esc_byte_clears_gap: assert property (@(posedge clk) disable iff (rst)
    (step && phase == akd_pkg::PH_ESC && !mode) |=> gap_counter == '0)
    else $error("gap counter not cleared by a byte after escape");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    body_count <= akd_pkg::CNT_LIM)
    else $error("body count beyond sequence limit");

  a_char_from_idle: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == akd_pkg::KEY_CHAR) |-> phase != akd_pkg::PH_ESC
      && phase != akd_pkg::PH_BODY)
    else $error("character key decoded inside an escape sequence");

  a_result_ends_seq: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid) |=> phase == akd_pkg::PH_IDLE)
    else $error("phase not idle after a key was decoded");
`endif

endmodule

>>> hdl/ansi_key_sequence_decoder.sv
// ansi_key_sequence_decoder: top level with input word register, result register
// and configuration port; depends on akd_pkg and akd_core
//
// usage
//   input stream s_*: one word per byte or tick; s_tuser is the mode flag
//   (0 byte, 1 tick), s_tdata the received byte
//   output stream m_*: at most one key event per word; m_tuser the key kind,
//   m_tdata the character byte for character keys, else zero
//   apb port: register 0 at address 0 holds the gap length in ticks (reset 40)
//   key path: a word that gives a key goes from the input register through the
//   decode stage into the result register, which then raises m_tvalid;
//   bytes and ticks that only advance a sequence give nothing
//   throughput: one word per cycle while no held result blocks the decode stage;
//   the decode stage between the input register and the result register is combinational
//   stall: a held result blocks only words that give a key; the input
//   register still takes a word while a result waits, then s_tready drops if that word gives a key
//   reset: synchronous; sequence state idle, both registers empty
//   the user must write the gap register only while the block is idle; the block does not enforce it
module ansi_key_sequence_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] char_code
  output logic [3:0]  m_tuser,   // [3:0] key_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                       in_valid;
  logic                       in_mode;
  logic [7:0]                 in_byte;
  logic [akd_pkg::GAP_W-1:0]  gap_ticks;
  logic                       step;
  akd_pkg::result_t           res;
  logic                       reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[2] == 1'b0;
  assign prdata  = reg_hit ? {{(32 - akd_pkg::GAP_W){1'b0}}, gap_ticks} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks <= akd_pkg::GAP_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      gap_ticks <= pwdata[akd_pkg::GAP_W-1:0];
    end
  end

  // decode stage advances on a valid input word unless it has a key and the result register is blocked
  assign step     = in_valid && (!res.valid || !m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  akd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .mode       (in_mode),
    .byte_value (in_byte),
    .gap_ticks  (gap_ticks),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      m_tuser <= res.kind;
      m_tdata <= res.code;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(step && res.valid))
    else $error("pending result overwritten");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !step) |=> in_valid && $stable(in_byte) && $stable(in_mode))
    else $error("input word lost while decode stage stalled");

  a_char_has_code: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && res.kind != akd_pkg::KEY_CHAR) |-> res.code == '0)
    else $error("nonzero code on a non-character key");
`endif

endmodule

>>> test/ansi_key_sequence_decoder_tb.sv
`timescale 1ns / 1ps
// ansi_key_sequence_decoder_tb: self-checking bench for the terminal key decoder
// drives byte and tick words, predicts key events from its own model of the decoder
// depends on akd_pkg and ansi_key_sequence_decoder
module ansi_key_sequence_decoder_tb;

  localparam logic [2:0] ADDR_GAP   = 3'd0;
  localparam logic [2:0] ADDR_SPARE = 3'd4;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
  } term_word_t;

  typedef struct {
    akd_pkg::key_t kind;
    logic [7:0]    code;
  } key_event_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] byte_value
  logic        s_tuser = 1'b0;    // [0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [7:0] char_code
  logic [3:0]  m_tuser;           // [3:0] key_kind
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  term_word_t pending_words[$];
  key_event_t expected_keys[$];

  // decoder state as the bench sees it
  akd_pkg::phase_t seq_phase = akd_pkg::PH_IDLE;
  logic [6:0]  body_len = 7'd0;
  logic [7:0]  body_first = 8'h00;
  logic [7:0]  body_second = 8'h00;
  logic [15:0] gap_count = 16'd0;
  logic [15:0] gap_reg = akd_pkg::GAP_RST;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int phase_words = 0;
  int words_sent = 0;
  int keys_checked = 0;
  int errors = 0;
  int quiet_cycles = 0;

  ansi_key_sequence_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit gap_elapsed();
    logic [15:0] limit;
    limit = (gap_reg == 16'd0) ? 16'd1 : gap_reg;
    if (gap_count != akd_pkg::GAP_SAT) gap_count = gap_count + 16'd1;
    return gap_count >= limit;
  endfunction

  function automatic akd_pkg::key_t body_key();
    akd_pkg::key_t k;
    k = akd_pkg::KEY_NONE;
    if (body_len == 7'd1) begin
      case (body_first)
        akd_pkg::CH_UP:    k = akd_pkg::KEY_UP;
        akd_pkg::CH_DOWN:  k = akd_pkg::KEY_DOWN;
        akd_pkg::CH_RIGHT: k = akd_pkg::KEY_RIGHT;
        akd_pkg::CH_LEFT:  k = akd_pkg::KEY_LEFT;
        default:           k = akd_pkg::KEY_NONE;
      endcase
    end else if (body_len == 7'd2 && body_second == akd_pkg::CH_TILDE) begin
      if (body_first == akd_pkg::CH_FIVE) k = akd_pkg::KEY_LEFT;
      else if (body_first == akd_pkg::CH_SIX) k = akd_pkg::KEY_RIGHT;
    end
    return k;
  endfunction

  function automatic akd_pkg::key_t byte_key(input logic [7:0] b);
    if (b == akd_pkg::CH_CR || b == akd_pkg::CH_LF) return akd_pkg::KEY_ENTER;
    if (b == akd_pkg::CH_SPACE) return akd_pkg::KEY_REFRESH;
    if (b == akd_pkg::CH_BS || b == akd_pkg::CH_DEL) return akd_pkg::KEY_ERASE;
    if (b == akd_pkg::CH_NAK) return akd_pkg::KEY_CLEAR;
    if (b == akd_pkg::CH_ETX) return akd_pkg::KEY_QUIT;
    if (b >= akd_pkg::CH_PRINT) return akd_pkg::KEY_CHAR;
    return akd_pkg::KEY_NONE;
  endfunction

  // advance the bench copy of the decoder by one accepted word
  task automatic decode_word(input logic tick, input logic [7:0] b);
    key_event_t ev;
    bit fire;
    fire = 1'b0;
    ev.kind = akd_pkg::KEY_NONE;
    ev.code = 8'h00;
    case (seq_phase)
      akd_pkg::PH_ESC: begin
        if (tick) begin
          if (gap_elapsed()) begin
            seq_phase = akd_pkg::PH_IDLE;
            ev.kind = akd_pkg::KEY_BACK;
            fire = 1'b1;
          end
        end else begin
          gap_count = 16'd0;
          if (b == akd_pkg::CH_CSI || b == akd_pkg::CH_SS3) begin
            seq_phase = akd_pkg::PH_BODY;
            body_len = 7'd0;
            body_first = 8'h00;
            body_second = 8'h00;
          end else begin
            seq_phase = akd_pkg::PH_IDLE;
            fire = 1'b1;
          end
        end
      end
      akd_pkg::PH_BODY: begin
        if (tick) begin
          if (gap_elapsed()) begin
            seq_phase = akd_pkg::PH_IDLE;
            ev.kind = body_key();
            fire = 1'b1;
          end
        end else begin
          gap_count = 16'd0;
          if (body_len == 7'd0) body_first = b;
          else if (body_len == 7'd1) body_second = b;
          if (body_len != akd_pkg::CNT_SAT) body_len = body_len + 7'd1;
          if ((b >= akd_pkg::CH_FIN_LO && b <= akd_pkg::CH_FIN_HI)
              || body_len >= akd_pkg::CNT_LIM) begin
            seq_phase = akd_pkg::PH_IDLE;
            ev.kind = body_key();
            fire = 1'b1;
          end
        end
      end
      default: begin
        seq_phase = akd_pkg::PH_IDLE;
        if (!tick) begin
          if (b == akd_pkg::CH_ESC) begin
            seq_phase = akd_pkg::PH_ESC;
            gap_count = 16'd0;
            body_len = 7'd0;
          end else begin
            ev.kind = byte_key(b);
            if (ev.kind == akd_pkg::KEY_CHAR) ev.code = b;
            fire = 1'b1;
          end
        end
      end
    endcase
    if (fire) expected_keys.push_back(ev);
  endtask

  // sender
  always @(posedge clk) begin : drv
    term_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
      s_tuser <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_word(s_tuser, s_tdata);
        words_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          w = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= w.data;
          s_tuser <= w.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : mon
    key_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_keys.size() == 0) begin
        $error("key event with none expected: key_kind %0d char_code %0d",
               m_tuser, m_tdata);
        errors++;
      end else begin
        want = expected_keys.pop_front();
        if (m_tuser !== want.kind) begin
          $error("key_kind: expected %0d, got %0d", want.kind, m_tuser);
          errors++;
        end
        if (m_tdata !== want.code) begin
          $error("char_code: expected %0d, got %0d", want.code, m_tdata);
          errors++;
        end
        keys_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ansi_key_sequence_decoder_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_word(input logic mode, input logic [7:0] b);
    term_word_t w;
    w.mode = mode;
    w.data = b;
    pending_words.push_back(w);
    phase_words++;
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) push_word(1'b1, 8'($urandom));
  endtask

  function automatic logic [7:0] inner_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b >= akd_pkg::CH_FIN_LO && b <= akd_pkg::CH_FIN_HI) b = b - akd_pkg::CH_FIN_LO;
    return b;
  endfunction

  // ticks that stay short of the gap
  task automatic push_short_pause(input int eff);
    if ($urandom_range(4) == 0) push_ticks($urandom_range(eff - 1, 0));
  endtask

  task automatic push_random_burst();
    int pick;
    int eff;
    int n;
    eff = (gap_reg == 16'd0) ? 1 : int'(gap_reg);
    pick = $urandom_range(99);
    if (pick < 25) begin
      push_word(1'b0, 8'($urandom));
    end else if (pick < 33) begin
      push_ticks($urandom_range(eff + 2, 1));
    end else if (pick < 40) begin
      push_word(1'($urandom_range(1)), 8'($urandom));
    end else begin
      push_word(1'b0, akd_pkg::CH_ESC);
      push_short_pause(eff);
      pick = $urandom_range(99);
      if (pick < 10) begin
        push_ticks(eff);
      end else if (pick < 18) begin
        push_word(1'b0, 8'($urandom));
      end else begin
        push_word(1'b0, $urandom_range(1) ? akd_pkg::CH_CSI : akd_pkg::CH_SS3);
        push_short_pause(eff);
        pick = $urandom_range(99);
        if (pick < 35) begin
          push_word(1'b0, akd_pkg::CH_UP + 8'($urandom_range(3)));
        end else if (pick < 55) begin
          push_word(1'b0, $urandom_range(1) ? akd_pkg::CH_FIVE : akd_pkg::CH_SIX);
          push_short_pause(eff);
          push_word(1'b0, $urandom_range(3) != 0 ? akd_pkg::CH_TILDE : 8'($urandom));
        end else if (pick < 75) begin
          n = $urandom_range(4);
          for (int i = 0; i < n; i++) push_word(1'b0, 8'($urandom_range(8'h3f, 8'h20)));
          push_word(1'b0, 8'($urandom_range(akd_pkg::CH_FIN_HI, akd_pkg::CH_FIN_LO)));
        end else if (pick < 85) begin
          n = $urandom_range(akd_pkg::SEQ_MAX + 3, akd_pkg::SEQ_MAX - 2);
          for (int i = 0; i < n; i++) push_word(1'b0, inner_byte());
        end else begin
          n = $urandom_range(2);
          for (int i = 0; i < n; i++) push_word(1'b0, inner_byte());
          push_ticks(eff);
        end
      end
    end
  endtask

  // wait for every word to go in and every key event to come out
  task automatic drain();
    while (pending_words.size() != 0 || s_tvalid || expected_keys.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // drain, then close any open escape sequence and drain again
  task automatic quiesce();
    drain();
    if (seq_phase != akd_pkg::PH_IDLE) begin
      push_word(1'b0, 8'h7a);
      drain();
    end
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_GAP) gap_reg = data[15:0];
  endtask

  task automatic apb_check_gap();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_GAP;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== gap_reg) begin
      $error("escape_gap_ticks: expected %0d, got %0d", gap_reg, prdata[15:0]);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_phase(input logic [15:0] gap, input int idle, input int stall,
                              input int words, input bit hold);
    apb_write(ADDR_GAP, {16'd0, gap});
    apb_check_gap();
    tx_idle_pct = idle;
    rx_stall_pct = stall;
    phase_words = 0;
    while (phase_words < words) push_random_burst();
    if (hold) hold_token++;
    quiesce();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at the reset gap
    apb_check_gap();
    push_word(1'b0, akd_pkg::CH_CR);
    push_word(1'b0, akd_pkg::CH_LF);
    push_word(1'b0, akd_pkg::CH_SPACE);
    push_word(1'b0, akd_pkg::CH_BS);
    push_word(1'b0, akd_pkg::CH_DEL);
    push_word(1'b0, akd_pkg::CH_NAK);
    push_word(1'b0, akd_pkg::CH_ETX);
    push_word(1'b0, 8'h00);
    push_word(1'b0, 8'h1f);
    push_word(1'b0, akd_pkg::CH_PRINT);
    push_word(1'b0, 8'hff);
    push_word(1'b1, 8'hff);
    push_word(1'b0, akd_pkg::CH_ESC);
    push_word(1'b0, akd_pkg::CH_CSI);
    push_word(1'b0, akd_pkg::CH_UP);
    push_word(1'b0, akd_pkg::CH_ESC);
    push_word(1'b0, akd_pkg::CH_SS3);
    push_word(1'b0, akd_pkg::CH_DOWN);
    push_word(1'b0, akd_pkg::CH_ESC);
    push_word(1'b0, akd_pkg::CH_CSI);
    push_word(1'b0, akd_pkg::CH_RIGHT);
    push_word(1'b0, akd_pkg::CH_ESC);
    push_word(1'b0, akd_pkg::CH_SS3);
    push_word(1'b0, akd_pkg::CH_LEFT);
    push_word(1'b0, akd_pkg::CH_ESC);
    push_word(1'b0, akd_pkg::CH_CSI);
    push_word(1'b0, akd_pkg::CH_FIVE);
    push_word(1'b0, akd_pkg::CH_TILDE);
    push_word(1'b0, akd_pkg::CH_ESC);
    push_word(1'b0, akd_pkg::CH_CSI);
    push_word(1'b0, akd_pkg::CH_SIX);
    push_word(1'b0, akd_pkg::CH_TILDE);
    push_word(1'b0, akd_pkg::CH_ESC);
    push_word(1'b0, 8'h78);
    push_word(1'b0, akd_pkg::CH_ESC);
    push_word(1'b0, akd_pkg::CH_CSI);
    push_word(1'b0, 8'h31);
    push_word(1'b0, 8'h3b);
    push_word(1'b0, 8'h48);
    // lone escape left to time out
    push_word(1'b0, akd_pkg::CH_ESC);
    push_ticks(int'(akd_pkg::GAP_RST));
    // introducer with nothing after it
    push_word(1'b0, akd_pkg::CH_ESC);
    push_word(1'b0, akd_pkg::CH_CSI);
    push_ticks(int'(akd_pkg::GAP_RST));
    // body cut off at the length limit
    push_word(1'b0, akd_pkg::CH_ESC);
    push_word(1'b0, akd_pkg::CH_CSI);
    for (int i = 0; i < akd_pkg::SEQ_MAX; i++) push_word(1'b0, 8'h31);
    quiesce();

    random_phase(16'd3, 0, 0, 60, 1'b1);
    random_phase(16'd1, 82, 0, 60, 1'b0);
    random_phase(16'd0, 0, 82, 60, 1'b0);
    random_phase(16'd7, 7, 7, 60, 1'b0);
    apb_write(ADDR_SPARE, 32'h0000_0002);
    apb_check_gap();
    random_phase(16'd7, 7, 7, 60, 1'b0);

    // widest gap: pauses far short of it never end a sequence
    apb_write(ADDR_GAP, 32'h0000_ffff);
    apb_check_gap();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    push_word(1'b0, akd_pkg::CH_ESC);
    push_ticks(20);
    push_word(1'b0, akd_pkg::CH_CSI);
    push_word(1'b0, akd_pkg::CH_FIVE);
    push_ticks(20);
    push_word(1'b0, akd_pkg::CH_TILDE);
    push_word(1'b0, akd_pkg::CH_ESC);
    push_ticks(10);
    push_word(1'b0, 8'h78);
    quiesce();

    random_phase(16'd5, 0, 0, 55, 1'b0);

    repeat (10) @(posedge clk);
    $display("%0d words driven, %0d key events checked", words_sent, keys_checked);
    $display("gaps 40/3/1/0/7/65535/5, long output hold, idle and stall mixes");
    if (errors == 0) begin
      $display("ansi_key_sequence_decoder_tb passed");
    end else begin
      $display("ansi_key_sequence_decoder_tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/akd_pkg.sv
hdl/akd_core.sv
hdl/ansi_key_sequence_decoder.sv
test/ansi_key_sequence_decoder_tb.sv
